// ===== src/gtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtc_pkg: shared types and constants for the GPS time to calendar converter
// Calendar tables, time divisors and the date result bundle.
// ----------------------------------------------------------------------------
package gtc_pkg;

    localparam int unsigned SECS_DAY        = 86400;
    localparam int unsigned SECS_HOUR       = 3600;
    localparam int unsigned SECS_MIN        = 60;
    localparam int unsigned DAYS_FOUR_YEARS = 1461;
    localparam int unsigned DAYS_LEAP_YEAR  = 366;
    localparam int unsigned DAYS_YEAR       = 365;
    localparam int unsigned BASE_YEAR       = 80;
    // GPS epoch (6 Jan 1980) is day 5 counted from 1 Jan 1980
    localparam int unsigned EPOCH_DAY       = 5;

    // reciprocals: x / d == (x * M) >> S over the ranges used
    localparam int unsigned DAY_RECIP  = 24856;  // (secs >> 7) / 675, S = 24
    localparam int unsigned HOUR_RECIP = 4661;   // (sod >> 4) / 225, S = 20
    localparam int unsigned MIN_RECIP  = 4370;   // rsec / 60, S = 18

    localparam logic [8:0] CUM_NORMAL [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] CUM_LEAP [0:12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
    } gtc_date_t;

endpackage

// ===== src/gtc_date.sv =====
// ----------------------------------------------------------------------------
// gtc_date: day count to calendar date pipeline
// Five register stages: four-year cycle, remainder, year and day of year,
// month, day of month. Advances only when en is high.
// ----------------------------------------------------------------------------
module gtc_date #(
    parameter int TOT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [TOT_BITS-1:0]  tot,
    output gtc_pkg::gtc_date_t   date
);
    import gtc_pkg::*;

    localparam int QS        = TOT_BITS + 11;
    localparam int QMB       = TOT_BITS + 1;
    localparam int QUAD_BITS = TOT_BITS - 10;
    localparam longint unsigned QM =
        ((64'd1 << QS) / 64'd1461) + 64'd1;

    // stage 1: four-year cycle count
    logic [QMB-1:0]            qm_c;
    logic [TOT_BITS+QMB-1:0]   qprod;
    logic [QUAD_BITS-1:0]      quad_next, quad1_reg, quad2_reg;
    logic [TOT_BITS-1:0]       tot1_reg;

    assign qm_c      = QM[QMB-1:0];
    assign qprod     = (TOT_BITS+QMB)'(tot) * (TOT_BITS+QMB)'(qm_c);
    assign quad_next = qprod[TOT_BITS+QMB-1:QS];

    // stage 2: day within the four-year cycle
    logic [TOT_BITS-1:0] qmul, rem_full;
    logic [10:0]         rem_next, rem_reg;

    assign qmul     = TOT_BITS'(quad1_reg) * TOT_BITS'(DAYS_FOUR_YEARS);
    assign rem_full = tot1_reg - qmul;
    assign rem_next = rem_full[10:0];

    // stage 3: year in cycle and day of year
    logic [10:0] r2;
    logic [1:0]  yy;
    logic [8:0]  doy_next, doy3_reg, doy4_reg;
    logic [7:0]  year_next, year3_reg, year4_reg, year5_reg;
    logic [10:0] r2b, r2c;

    assign r2  = rem_reg - 11'(DAYS_LEAP_YEAR);
    assign r2b = r2 - 11'(DAYS_YEAR);
    assign r2c = r2 - 11'(2 * DAYS_YEAR);

    always_comb
    begin
        if (rem_reg < 11'(DAYS_LEAP_YEAR))
        begin
            yy       = 2'd0;
            doy_next = rem_reg[8:0];
        end
        else if (r2 < 11'(DAYS_YEAR))
        begin
            yy       = 2'd1;
            doy_next = r2[8:0];
        end
        else if (r2 < 11'(2 * DAYS_YEAR))
        begin
            yy       = 2'd2;
            doy_next = r2b[8:0];
        end
        else
        begin
            yy       = 2'd3;
            doy_next = r2c[8:0];
        end
    end

    assign year_next = 8'({quad2_reg, yy}) + 8'(BASE_YEAR);

    // stage 4: month by counting table boundaries passed
    logic       leap3_reg, leap4_reg;
    logic [3:0] month_next, month4_reg, month5_reg;

    always_comb
    begin
        month_next = 4'd1;
        for (int m = 1; m < 12; m++)
        begin
            if (doy3_reg >= (leap3_reg ? CUM_LEAP[m] : CUM_NORMAL[m]))
                month_next = month_next + 4'd1;
        end
    end

    // stage 5: day of month
    logic [8:0] mstart, dsum;
    logic [4:0] day_next, day5_reg;

    assign mstart   = leap4_reg ? CUM_LEAP[month4_reg - 4'd1]
                                : CUM_NORMAL[month4_reg - 4'd1];
    assign dsum     = doy4_reg - mstart + 9'd1;
    assign day_next = dsum[4:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad1_reg  <= quad_next;
            tot1_reg   <= tot;
            quad2_reg  <= quad1_reg;
            rem_reg    <= rem_next;
            doy3_reg   <= doy_next;
            year3_reg  <= year_next;
            leap3_reg  <= (yy == 2'd0);
            doy4_reg   <= doy3_reg;
            year4_reg  <= year3_reg;
            leap4_reg  <= leap3_reg;
            month4_reg <= month_next;
            year5_reg  <= year4_reg;
            month5_reg <= month4_reg;
            day5_reg   <= day_next;
        end
    end

    assign date.year  = year5_reg;
    assign date.month = month5_reg;
    assign date.day   = day5_reg;

endmodule

// ===== src/gps_time_to_calendar.sv =====
// ----------------------------------------------------------------------------
// gps_time_to_calendar: GPS week and seconds to UTC calendar date and time
// Subtracts the leap-second offset, splits seconds into day and time of day,
// and turns days since 1 Jan 1980 into year, month and day.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | gps_week, seconds_of_week, utc_offset
//  out     | out_valid / out_ready| valid_res, year_since_1900, month,
//          |                      | day_of_month, hour, minute, second
//
// One word in per cycle while the pipeline is not held, one word out per
// input word. Eight register stages; the stages carry the chain of
// constant-reciprocal multiplies (days, hours, minutes, four-year cycles),
// each multiply followed by a stage that subtracts its product back.
// The whole pipeline moves on one enable: it holds when the output word is
// waiting and out_ready is low, so in_ready follows out_ready in that case.
// Reset clears the stage valid bits only.
//
module gps_time_to_calendar #(
    parameter int WEEK_BITS = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WEEK_BITS-1:0] gps_week,
    input  logic [19:0]          seconds_of_week,
    input  logic [7:0]           utc_offset,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 valid_res,
    output logic [7:0]           year_since_1900,
    output logic [3:0]           month,
    output logic [4:0]           day_of_month,
    output logic [4:0]           hour,
    output logic [5:0]           minute,
    output logic [5:0]           second
);
    import gtc_pkg::*;

    localparam int TOT_BITS = WEEK_BITS + 3;
    localparam int NSTG     = 8;

    // one enable for every stage; a held output freezes the pipe
    logic            adv;
    logic [NSTG:1]   vld_reg;
    logic [NSTG:1]   ok_reg;   // offset-corrected seconds not negative

    assign adv      = !vld_reg[NSTG] || out_ready;
    assign in_ready = adv;

    // stage 1: offset correction
    logic [20:0]           sdiff;
    logic                  ok_next;
    logic [19:0]           secs_next, secs1_reg, secs2_reg;
    logic [WEEK_BITS-1:0]  week1_reg;

    assign sdiff     = {1'b0, seconds_of_week} - {13'd0, utc_offset};
    assign ok_next   = !sdiff[20];
    assign secs_next = sdiff[19:0];

    // stage 2: whole days (86400 = 675 * 128), week times seven
    logic [27:0]           dprod;
    logic [3:0]            days_next, days2_reg;
    logic [TOT_BITS-1:0]   week7_next, week7_reg;

    assign dprod      = 28'(secs1_reg[19:7]) * 28'(DAY_RECIP);
    assign days_next  = dprod[27:24];
    assign week7_next = {week1_reg, 3'd0} - TOT_BITS'(week1_reg);

    // stage 3: seconds of day, days since 1 Jan 1980
    logic [19:0]           dsec;
    logic [16:0]           sod_next, sod3_reg, sod4_reg;
    logic [TOT_BITS-1:0]   tot_next, tot_reg;

    assign dsec     = secs2_reg - 20'(days2_reg) * 20'(SECS_DAY);
    assign sod_next = dsec[16:0];
    assign tot_next = week7_reg + TOT_BITS'(days2_reg) + TOT_BITS'(EPOCH_DAY);

    // stage 4: hour (3600 = 225 * 16)
    logic [25:0] hprod;
    logic [4:0]  hour_next, hour4_reg, hour5_reg, hour6_reg, hour7_reg;

    assign hprod     = 26'(sod3_reg[16:4]) * 26'(HOUR_RECIP);
    assign hour_next = hprod[24:20];

    // stage 5: seconds of hour
    logic [16:0] hsec;
    logic [11:0] rsec_next, rsec5_reg, rsec6_reg;

    assign hsec      = sod4_reg - 17'(hour4_reg) * 17'(SECS_HOUR);
    assign rsec_next = hsec[11:0];

    // stage 6: minute
    logic [24:0] mprod;
    logic [5:0]  min_next, min6_reg, min7_reg;

    assign mprod    = 25'(rsec5_reg) * 25'(MIN_RECIP);
    assign min_next = mprod[23:18];

    // stage 7: second
    logic [11:0] msec;
    logic [5:0]  sec_next, sec7_reg;

    assign msec     = rsec6_reg - 12'(min6_reg) * 12'(SECS_MIN);
    assign sec_next = msec[5:0];

    // stage 8: output register, time fields zeroed for invalid words
    logic [4:0] hour8_reg;
    logic [5:0] min8_reg, sec8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-1:1], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg    <= {ok_reg[NSTG-1:1], ok_next};
            secs1_reg <= secs_next;
            week1_reg <= gps_week;
            secs2_reg <= secs1_reg;
            days2_reg <= days_next;
            week7_reg <= week7_next;
            sod3_reg  <= sod_next;
            tot_reg   <= tot_next;
            sod4_reg  <= sod3_reg;
            hour4_reg <= hour_next;
            hour5_reg <= hour4_reg;
            rsec5_reg <= rsec_next;
            hour6_reg <= hour5_reg;
            rsec6_reg <= rsec5_reg;
            min6_reg  <= min_next;
            hour7_reg <= hour6_reg;
            min7_reg  <= min6_reg;
            sec7_reg  <= sec_next;
            hour8_reg <= ok_reg[7] ? hour7_reg : 5'd0;
            min8_reg  <= ok_reg[7] ? min7_reg  : 6'd0;
            sec8_reg  <= ok_reg[7] ? sec7_reg  : 6'd0;
        end
    end

    // date path: stages 4 to 8
    gtc_date_t date;

    gtc_date #(
        .TOT_BITS (TOT_BITS)
    ) u_date (
        .clk  (clk),
        .en   (adv),
        .tot  (tot_reg),
        .date (date)
    );

    assign out_valid       = vld_reg[NSTG];
    assign valid_res       = ok_reg[NSTG];
    assign year_since_1900 = ok_reg[NSTG] ? date.year  : 8'd0;
    assign month           = ok_reg[NSTG] ? date.month : 4'd0;
    assign day_of_month    = ok_reg[NSTG] ? date.day   : 5'd0;
    assign hour            = hour8_reg;
    assign minute          = min8_reg;
    assign second          = sec8_reg;

endmodule
